/* hdl/lbr_pkg.sv */
// ----------------------------------------------------------------------------
// lbr_pkg: shared types and constants of the bounded lcg48 generator
// generator constants, field widths and the request/response bundles that
// pass between the sequencer and its multiply and divide units
// ----------------------------------------------------------------------------
`default_nettype none

package lbr_pkg;

    localparam int STATE_W   = 48;
    localparam int MULT_W    = 35;
    localparam int CHUNK_W   = 16;
    localparam int U_W       = 31;
    localparam int BOUND_W   = 31;
    localparam int DIVISOR_W = BOUND_W + 1;

    localparam logic [MULT_W-1:0]  LCG_MULT    = 35'h5DEECE66D;
    localparam logic [STATE_W-1:0] LCG_ADD     = 48'hB;
    localparam logic [BOUND_W-1:0] BOUND_RESET = 31'd10;

    typedef struct packed {
        logic               start;
        logic [STATE_W-1:0] src;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [STATE_W-1:0] result;
    } t_mul_rsp;

    typedef struct packed {
        logic                 start;
        logic [U_W-1:0]       dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [U_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

/* hdl/lbr_mul.sv */
// ----------------------------------------------------------------------------
// lbr_mul: lcg state advance unit
// computes (src * mult + add) mod 2^48 with one 16 x 35 multiplier,
// one 16-bit chunk of src per cycle, product registered before accumulation
// ----------------------------------------------------------------------------
`default_nettype none

module lbr_mul (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire lbr_pkg::t_mul_req i_req,
    output lbr_pkg::t_mul_rsp      o_rsp
);

    localparam int PROD_W = lbr_pkg::CHUNK_W + lbr_pkg::MULT_W;

    logic                        r_busy;
    logic                        r_done;
    logic [1:0]                  r_cnt;
    logic [lbr_pkg::STATE_W-1:0] r_src;
    logic [lbr_pkg::STATE_W-1:0] r_prod;
    logic                        r_pvld;
    logic [lbr_pkg::STATE_W-1:0] r_acc;

    logic [PROD_W-1:0]           w_prod;
    logic [lbr_pkg::STATE_W-1:0] w_prod_sh;

    assign w_prod = PROD_W'(r_src[lbr_pkg::CHUNK_W-1:0]) * PROD_W'(lbr_pkg::LCG_MULT);

    // place the partial product at its chunk offset, upper bits fall off mod 2^48
    always_comb begin
        unique case (r_cnt)
            2'd0:    w_prod_sh = w_prod[47:0];
            2'd1:    w_prod_sh = {w_prod[31:0], 16'd0};
            2'd2:    w_prod_sh = {w_prod[15:0], 32'd0};
            default: w_prod_sh = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
            r_pvld <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
                r_pvld <= 1'b0;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + 2'd1;
                r_pvld <= (r_cnt != 2'd3);
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_src <= i_req.src;
            r_acc <= lbr_pkg::LCG_ADD;
        end else if (r_busy) begin
            r_src  <= r_src >> lbr_pkg::CHUNK_W;
            r_prod <= w_prod_sh;
            if (r_pvld) begin
                r_acc <= r_acc + r_prod;
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

`default_nettype wire

/* hdl/lbr_div.sv */
// ----------------------------------------------------------------------------
// lbr_div: restoring remainder unit
// one quotient bit per cycle, one for each bit of the 31-bit dividend
// ----------------------------------------------------------------------------
`default_nettype none

module lbr_div (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire lbr_pkg::t_div_req i_req,
    output lbr_pkg::t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(lbr_pkg::U_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(lbr_pkg::U_W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [lbr_pkg::U_W-1:0]       r_num;
    logic [lbr_pkg::U_W-1:0]       r_rem;
    logic [lbr_pkg::DIVISOR_W-1:0] r_dsr;

    logic [lbr_pkg::DIVISOR_W-1:0] w_trial;
    logic [lbr_pkg::DIVISOR_W-1:0] w_diff;

    assign w_trial = {r_rem, r_num[lbr_pkg::U_W-1]};
    assign w_diff  = w_trial - r_dsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            // remainder stays below the divisor, so it fits in 31 bits
            r_rem <= (w_trial >= r_dsr) ? w_diff[lbr_pkg::U_W-1:0]
                                        : w_trial[lbr_pkg::U_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

/* hdl/lcg48_bounded_random.sv */
// ----------------------------------------------------------------------------
// lcg48_bounded_random: bounded integers from a 48-bit lcg
// java-style nextInt(bound) draw with optional reseed per transfer
// ----------------------------------------------------------------------------
// Each input transfer optionally reseeds the generator (state = seed ^
// 0x5DEECE66D) and then yields one value in 0 .. bound-1 on the output
// channel. A draw runs from the input transfer through the chunked
// multiplier that advances the state and hands off to the divider, then
// the bit-serial remainder unit, then the capture of the remainder and the
// rejection check, before the result lands in the output register. A
// rejected draw repeats the multiply, divide and check. The input side is
// not ready while a draw is running and comes back as the result lands, so
// the block takes no new input transfer until the previous draw is done. A
// finished value waits in the output register, so the next input transfer
// can start while the previous result is still unclaimed; a second
// finished value waits in the check state until the output register frees
// up. A bound register value of 0 means 2^31.
// Write the bound only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg48_bounded_random (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // configuration
    input  wire                         i_cfg_we,
    input  wire  [lbr_pkg::BOUND_W-1:0] i_cfg_data,
    // input channel
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire                         i_reseed,
    input  wire  [lbr_pkg::STATE_W-1:0] i_seed,
    // output channel
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic [lbr_pkg::U_W-1:0]     o_value
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_CHK  = 2'd3;

    localparam int SUM_W = lbr_pkg::DIVISOR_W + 1;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [lbr_pkg::BOUND_W-1:0]   r_bound;
    logic [lbr_pkg::STATE_W-1:0]   r_lcg;
    logic [lbr_pkg::U_W-1:0]       r_u;
    logic [lbr_pkg::U_W-1:0]       r_r;
    logic                          r_out_valid;
    logic [lbr_pkg::U_W-1:0]       r_value;

    lbr_pkg::t_mul_req             w_mul_req;
    lbr_pkg::t_mul_rsp             w_mul_rsp;
    lbr_pkg::t_div_req             w_div_req;
    lbr_pkg::t_div_rsp             w_div_rsp;

    logic                          w_in_xfer;
    logic                          w_out_free;
    logic [lbr_pkg::DIVISOR_W-1:0] w_divisor;
    logic [SUM_W-1:0]              w_sum;
    logic                          w_reject;
    logic                          w_emit;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    // output register can take a new value when empty or being drained now
    assign w_out_free = !r_out_valid || i_out_ready;

    // a zero bound stands for 2^31
    assign w_divisor = (r_bound == '0) ? {1'b1, {lbr_pkg::BOUND_W{1'b0}}}
                                       : {1'b0, r_bound};

    // reject while u - r + (bound - 1) overflows signed 32 bits
    assign w_sum    = SUM_W'(r_u) - SUM_W'(r_r) + SUM_W'(w_divisor) - SUM_W'(1);
    assign w_reject = |w_sum[SUM_W-1:lbr_pkg::U_W];
    assign w_emit   = (r_state == S_CHK) && !w_reject && w_out_free;

    // start the state advance on a new transfer or on a rejected draw
    always_comb begin
        w_mul_req.start = w_in_xfer || ((r_state == S_CHK) && w_reject);
        if (w_in_xfer && i_reseed) begin
            w_mul_req.src = i_seed ^ lbr_pkg::STATE_W'(lbr_pkg::LCG_MULT);
        end else begin
            w_mul_req.src = r_lcg;
        end
    end

    // top 31 bits of the advanced state go straight into the divider
    always_comb begin
        w_div_req.start    = (r_state == S_MUL) && w_mul_rsp.done;
        w_div_req.dividend = w_mul_rsp.result[lbr_pkg::STATE_W-1 -: lbr_pkg::U_W];
        w_div_req.divisor  = w_divisor;
    end

    lbr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    lbr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (w_mul_rsp.done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // redraw on reject, otherwise wait for room in the output register
                if (w_reject) begin
                    n_state = S_MUL;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bound     <= lbr_pkg::BOUND_RESET;
            r_lcg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_bound <= i_cfg_data;
            end
            if (w_div_req.start) begin
                r_lcg <= w_mul_rsp.result;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_div_req.start) begin
            r_u <= w_div_req.dividend;
        end
        if ((r_state == S_DIV) && w_div_rsp.done) begin
            r_r <= w_div_rsp.rem;
        end
        if (w_emit) begin
            r_value <= r_r;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

endmodule

`default_nettype wire

/* hdl/lbr_checker.sv */
// ----------------------------------------------------------------------------
// lbr_checker: port-level checks for the bounded lcg48 generator
// watches the top level's ports and a shadow copy of the bound register
// ----------------------------------------------------------------------------
`default_nettype none

module lbr_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_cfg_we,
    input wire [lbr_pkg::BOUND_W-1:0] i_cfg_data,
    input wire                        i_in_valid,
    input wire                        o_in_ready,
    input wire                        o_out_valid,
    input wire                        i_out_ready,
    input wire [lbr_pkg::U_W-1:0]     o_value
);

    logic [lbr_pkg::BOUND_W-1:0] r_bound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= lbr_pkg::BOUND_RESET;
        end else if (i_cfg_we) begin
            r_bound <= i_cfg_data;
        end
    end

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_value)))
        else $error("output result dropped or changed while stalled");

    // every value lies below the bound, zero bound meaning 2^31
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((r_bound == '0) || (o_value < r_bound)))
        else $error("output value not below the bound");

    // a draw runs through the multiply and divide units, so the input side goes busy after a transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##1 !o_in_ready)
        else $error("input ready again right after a transfer");

    // reset leaves the block idle with an empty output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after reset");

endmodule

bind lcg48_bounded_random lbr_checker u_lbr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_data  (i_cfg_data),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_value     (o_value)
);

`default_nettype wire
